FILE: hdl/gpb_pkg.sv
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared types and constants for the GPIO port bank controller.
// ----------------------------------------------------------------------------
package gpb_pkg;

  localparam int unsigned NumPorts    = 11;
  localparam int unsigned PinsPerPort = 16;
  localparam int unsigned AddrW       = (NumPorts > 1) ? $clog2(NumPorts) : 1;

  // Request codes.
  typedef enum logic [3:0] {
    ACT_SET       = 4'd0,
    ACT_CLEAR     = 4'd1,
    ACT_TOGGLE    = 4'd2,
    ACT_WRITE_PIN = 4'd3,
    ACT_READ_PIN  = 4'd4,
    ACT_WRITE_PORT= 4'd5,
    ACT_READ_PORT = 4'd6,
    ACT_SET_MODE  = 4'd7,
    ACT_GET_MODE  = 4'd8,
    ACT_SET_MUX   = 4'd9
  } act_e;

  // Complete per-port state, held as one memory word.
  typedef struct packed {
    logic [4*PinsPerPort-1:0] mux_sel;
    logic [2*PinsPerPort-1:0] pull;
    logic [PinsPerPort-1:0]   drive;
    logic [2*PinsPerPort-1:0] mode;
    logic [PinsPerPort-1:0]   out_lvl;
  } gpb_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
  } gpb_mem_ctl_t;

endpackage

FILE: hdl/gpio_port_bank_controller.sv
// ----------------------------------------------------------------------------
// gpio_port_bank_controller
// Bank of 16-pin GPIO ports with bit set/clear/toggle access, pin and port
// reads, and per-pin mode, output type, pull and alternate-function setup.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                  Payload
//   request   in          in_valid_i / in_ready_o    action_i .. alt_function_i
//   result    out         out_valid_o / out_ready_i  status_o .. pull_read_o
//
// For each item, the accept cycle launches a read of the addressed port's
// state word; in the read-modify-write state the word is modified, written
// back and the result is loaded into the output register. The state memory
// has a registered read port. Reset clears the entry valid bits, so every
// port reads as all zero; no clearing pass is needed. When the result
// register is still full, the block holds in its read-modify-write state
// until the result is taken.
//
module gpio_port_bank_controller (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [3:0]  port_i,
  input  logic [3:0]  pin_i,
  input  logic        pin_level_i,
  input  logic [15:0] port_word_i,
  input  logic [15:0] pad_levels_i,
  input  logic [1:0]  mode_select_i,
  input  logic        drive_type_i,
  input  logic [1:0]  pull_select_i,
  input  logic [3:0]  alt_function_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        pin_value_o,
  output logic [15:0] port_value_o,
  output logic [15:0] out_word_o,
  output logic [1:0]  mode_read_o,
  output logic        drive_read_o,
  output logic [1:0]  pull_read_o
);

  // Two-state sequencer: waiting for a request, or finishing one.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RMW  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Request captured at acceptance.
  logic [3:0]  action_q;
  logic [3:0]  port_q;
  logic [3:0]  pin_q;
  logic        pin_level_q;
  logic [15:0] port_word_q;
  logic [15:0] pad_levels_q;
  logic [1:0]  mode_select_q;
  logic        drive_type_q;
  logic [1:0]  pull_select_q;
  logic [3:0]  alt_function_q;
  logic        port_err_q;

  // Result register.
  logic        out_valid_q;
  logic        status_q;
  logic        pin_value_q;
  logic [15:0] port_value_q;
  logic [15:0] out_word_q;
  logic [1:0]  mode_read_q;
  logic        drive_read_q;
  logic [1:0]  pull_read_q;

  logic                  in_fire;
  logic                  port_err;
  logic                  res_load;
  logic                  entry_mod;
  gpb_pkg::gpb_entry_t   rd_entry;
  gpb_pkg::gpb_entry_t   wr_entry;
  gpb_pkg::gpb_mem_ctl_t mem_ctl;
  logic [15:0]           pin_mask;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign port_err   = ({1'b0, port_i} >= 5'(gpb_pkg::NumPorts));

  // The result can be loaded once the output register is free or emptying.
  assign res_load = (state_q == S_RMW) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q       <= action_i;
      port_q         <= port_i;
      pin_q          <= pin_i;
      pin_level_q    <= pin_level_i;
      port_word_q    <= port_word_i;
      pad_levels_q   <= pad_levels_i;
      mode_select_q  <= mode_select_i;
      drive_type_q   <= drive_type_i;
      pull_select_q  <= pull_select_i;
      alt_function_q <= alt_function_i;
      port_err_q     <= port_err;
    end
  end

  // Modify the state word read back for the pending request.
  assign pin_mask = 16'd1 << pin_q;

  always_comb begin
    wr_entry  = rd_entry;
    entry_mod = 1'b0;
    unique case (gpb_pkg::act_e'(action_q))
      gpb_pkg::ACT_SET: begin
        wr_entry.out_lvl = rd_entry.out_lvl | pin_mask;
        entry_mod        = 1'b1;
      end
      gpb_pkg::ACT_CLEAR: begin
        wr_entry.out_lvl = rd_entry.out_lvl & ~pin_mask;
        entry_mod        = 1'b1;
      end
      gpb_pkg::ACT_TOGGLE: begin
        wr_entry.out_lvl = rd_entry.out_lvl ^ pin_mask;
        entry_mod        = 1'b1;
      end
      gpb_pkg::ACT_WRITE_PIN: begin
        wr_entry.out_lvl[pin_q] = pin_level_q;
        entry_mod               = 1'b1;
      end
      gpb_pkg::ACT_WRITE_PORT: begin
        wr_entry.out_lvl = port_word_q;
        entry_mod        = 1'b1;
      end
      gpb_pkg::ACT_SET_MODE: begin
        wr_entry.mode[{pin_q, 1'b0} +: 2] = mode_select_q;
        wr_entry.drive[pin_q]             = drive_type_q;
        wr_entry.pull[{pin_q, 1'b0} +: 2] = pull_select_q;
        entry_mod                         = 1'b1;
      end
      gpb_pkg::ACT_SET_MUX: begin
        // Each pin's select sits at its own nibble of the 64-bit word.
        wr_entry.mux_sel[{pin_q, 2'b00} +: 4] = alt_function_q;
        entry_mod                             = 1'b1;
      end
      default: begin
        // Reads and unused codes leave the state alone.
      end
    endcase
  end

  assign mem_ctl.rd_en   = in_fire && !port_err;
  assign mem_ctl.rd_addr = port_i[gpb_pkg::AddrW-1:0];
  assign mem_ctl.wr_en   = res_load && !port_err_q && entry_mod;
  assign mem_ctl.wr_addr = port_q[gpb_pkg::AddrW-1:0];

  gpb_state_ram u_state_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_data_i (wr_entry),
    .rd_data_o (rd_entry)
  );

  // Result assembly; an out-of-range port reports status only.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q     <= port_err_q;
      pin_value_q  <= 1'b0;
      port_value_q <= '0;
      out_word_q   <= '0;
      mode_read_q  <= '0;
      drive_read_q <= 1'b0;
      pull_read_q  <= '0;
      if (!port_err_q) begin
        out_word_q <= wr_entry.out_lvl;
        if (gpb_pkg::act_e'(action_q) == gpb_pkg::ACT_READ_PIN) begin
          pin_value_q <= pad_levels_q[pin_q];
        end
        if (gpb_pkg::act_e'(action_q) == gpb_pkg::ACT_READ_PORT) begin
          port_value_q <= pad_levels_q;
        end
        if (gpb_pkg::act_e'(action_q) == gpb_pkg::ACT_GET_MODE) begin
          mode_read_q  <= rd_entry.mode[{pin_q, 1'b0} +: 2];
          drive_read_q <= rd_entry.drive[pin_q];
          pull_read_q  <= rd_entry.pull[{pin_q, 1'b0} +: 2];
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign pin_value_o  = pin_value_q;
  assign port_value_o = port_value_q;
  assign out_word_o   = out_word_q;
  assign mode_read_o  = mode_read_q;
  assign drive_read_o = drive_read_q;
  assign pull_read_o  = pull_read_q;

endmodule

FILE: hdl/gpb_state_ram.sv
// ----------------------------------------------------------------------------
// gpb_state_ram
// Per-port state memory with a registered read port and per-entry valid
// bits; an entry that was never written reads as all zero.
// ----------------------------------------------------------------------------
module gpb_state_ram (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpb_pkg::gpb_mem_ctl_t ctl_i,
  input  gpb_pkg::gpb_entry_t  wr_data_i,
  output gpb_pkg::gpb_entry_t  rd_data_o
);

  gpb_pkg::gpb_entry_t              mem_q [gpb_pkg::NumPorts];
  gpb_pkg::gpb_entry_t              rd_data_q;
  logic [gpb_pkg::NumPorts-1:0]     entry_vld_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        entry_vld_q[ctl_i.wr_addr] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= entry_vld_q[ctl_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: hdl/gpb_port_checker.sv
// ----------------------------------------------------------------------------
// gpb_port_checker
// Port-level checks for the GPIO port bank controller, bound to the top.
// ----------------------------------------------------------------------------
module gpb_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic        pin_value_o,
  input logic [15:0] port_value_o,
  input logic [15:0] out_word_o,
  input logic [1:0]  mode_read_o,
  input logic        drive_read_o,
  input logic [1:0]  pull_read_o
);

  // A result waiting to be taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o)
      && $stable(status_o))
    else $error("result changed while stalled");

  // One item is in flight at a time: no new request right after one is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A fresh result only follows a cycle in which the block was busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in flight");

  // An error result carries nothing but its status.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> out_word_o == 16'd0 && port_value_o == 16'd0
      && !pin_value_o && mode_read_o == 2'd0 && !drive_read_o
      && pull_read_o == 2'd0)
    else $error("error result carries data");

endmodule

bind gpio_port_bank_controller gpb_port_checker u_gpb_port_checker (.*);
